// File: hw/rtl/fqrr_pkg.sv
// ----------------------------------------------------------------------------
// fqrr_pkg
// Shared types and constants for the four-queue round-robin merge.
// ----------------------------------------------------------------------------
package fqrr_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int TAG_BITS    = 32;
  localparam int NUM_QUEUES  = 4;

  localparam int POS_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W = 2;
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  typedef enum logic [1:0] {
    REQ_SELECT = 2'd0,
    REQ_PUSH   = 2'd1,
    REQ_POP    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_NO_QUEUE = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3
  } status_t;

  // Direction codes as they arrive on a select beat.
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_WEST  = 3'd1;
  localparam logic [2:0] DIR_SOUTH = 3'd2;
  localparam logic [2:0] DIR_NORTH = 3'd3;
  localparam logic [2:0] DIR_EAST  = 3'd4;

  // Service order indexes.
  localparam logic [QIDX_W-1:0] Q_WEST  = 2'd0;
  localparam logic [QIDX_W-1:0] Q_NORTH = 2'd1;
  localparam logic [QIDX_W-1:0] Q_SOUTH = 2'd2;
  localparam logic [QIDX_W-1:0] Q_EAST  = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [QIDX_W-1:0] source_queue;
    logic              pop_done;
  } fqrr_res_t;

  function automatic logic [QIDX_W-1:0] dir_to_index(input logic [2:0] dir);
    logic [QIDX_W-1:0] idx;
    case (dir)
      DIR_WEST:  idx = Q_WEST;
      DIR_SOUTH: idx = Q_SOUTH;
      DIR_NORTH: idx = Q_NORTH;
      default:   idx = Q_EAST;
    endcase
    return idx;
  endfunction

endpackage

// File: hw/rtl/fqrr_if.sv
// ----------------------------------------------------------------------------
// fqrr_if
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqrr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [2:0]  direction;
  logic [31:0] plane_tag;

  modport source (output valid, output req_type, output direction, output plane_tag,
                  input ready);
  modport sink   (input valid, input req_type, input direction, input plane_tag,
                  output ready);
endinterface

interface fqrr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_tag;
  logic [1:0]  source_queue;

  modport source (output valid, output status, output out_tag, output source_queue,
                  input ready);
  modport sink   (input valid, input status, input out_tag, input source_queue,
                  output ready);
endinterface

// File: hw/rtl/fqrr_ram.sv
// ----------------------------------------------------------------------------
// fqrr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fqrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/fqrr_queue_ctrl.sv
// ----------------------------------------------------------------------------
// fqrr_queue_ctrl
// Queue pointers, current selection and the round-robin pick; drives the
// tag store for one request per cycle while en is high.
// ----------------------------------------------------------------------------
module fqrr_queue_ctrl import fqrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [1:0]          req_type,
  input  logic [2:0]          direction,
  input  logic [TAG_BITS-1:0] plane_tag,
  output fqrr_res_t           res,
  output logic                mem_wr_en,
  output logic [ADDR_W-1:0]   mem_wr_addr,
  output logic [TAG_BITS-1:0] mem_wr_data,
  output logic                mem_rd_en,
  output logic [ADDR_W-1:0]   mem_rd_addr
);

  logic [POS_W-1:0]  head_r  [NUM_QUEUES];
  logic [POS_W-1:0]  head_nxt[NUM_QUEUES];
  logic [CNT_W-1:0]  count_r  [NUM_QUEUES];
  logic [CNT_W-1:0]  count_nxt[NUM_QUEUES];
  logic [2:0]        selected_r, selected_nxt;
  logic [QIDX_W-1:0] next_served_r, next_served_nxt;

  logic [QIDX_W-1:0] push_q;
  logic [CNT_W:0]    tail_sum;
  logic [POS_W-1:0]  tail_pos;
  logic              pick_found;
  logic [QIDX_W-1:0] pick_q;
  logic [QIDX_W-1:0] cand_q;
  logic [POS_W:0]    head_inc;
  logic [POS_W-1:0]  head_wrap;
  logic              sel_valid;

  always_comb begin
    // Round-robin search starting at the next queue to be served.
    pick_found = 1'b0;
    pick_q     = Q_WEST;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      cand_q = next_served_r + QIDX_W'(i);
      if (!pick_found && (count_r[cand_q] != '0)) begin
        pick_found = 1'b1;
        pick_q     = cand_q;
      end
    end
  end

  always_comb begin
    sel_valid = (selected_r != DIR_NONE);
    push_q    = dir_to_index(selected_r);
    tail_sum  = (CNT_W+1)'(head_r[push_q]) + (CNT_W+1)'(count_r[push_q]);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_pos = POS_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH));
    end else begin
      tail_pos = POS_W'(tail_sum);
    end
    head_inc = (POS_W+1)'(head_r[pick_q]) + (POS_W+1)'(1);
    if (head_inc >= (POS_W+1)'(QUEUE_DEPTH)) begin
      head_wrap = '0;
    end else begin
      head_wrap = POS_W'(head_inc);
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      head_nxt[i]  = head_r[i];
      count_nxt[i] = count_r[i];
    end
    selected_nxt     = selected_r;
    next_served_nxt  = next_served_r;
    res.status       = ST_DONE;
    res.source_queue = Q_WEST;
    res.pop_done     = 1'b0;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = ADDR_W'(push_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_pos);
    mem_wr_data      = plane_tag;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = ADDR_W'(pick_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_r[pick_q]);

    case (req_t'(req_type))
      REQ_SELECT: begin
        if (direction inside {DIR_WEST, DIR_SOUTH, DIR_NORTH, DIR_EAST}) begin
          selected_nxt = direction;
        end
      end
      REQ_PUSH: begin
        if (!sel_valid) begin
          res.status = ST_NO_QUEUE;
        end else if (count_r[push_q] == CNT_W'(QUEUE_DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          mem_wr_en         = en;
          count_nxt[push_q] = count_r[push_q] + CNT_W'(1);
        end
      end
      REQ_POP: begin
        if (!pick_found) begin
          res.status = ST_EMPTY;
        end else begin
          mem_rd_en         = en;
          res.source_queue  = pick_q;
          res.pop_done      = 1'b1;
          head_nxt[pick_q]  = head_wrap;
          count_nxt[pick_q] = count_r[pick_q] - CNT_W'(1);
          next_served_nxt   = pick_q + QIDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
      selected_r    <= DIR_NONE;
      next_served_r <= Q_WEST;
    end else if (en) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i]  <= head_nxt[i];
        count_r[i] <= count_nxt[i];
      end
      selected_r    <= selected_nxt;
      next_served_r <= next_served_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[0] <= CNT_W'(QUEUE_DEPTH)) && (count_r[1] <= CNT_W'(QUEUE_DEPTH)) &&
    (count_r[2] <= CNT_W'(QUEUE_DEPTH)) && (count_r[3] <= CNT_W'(QUEUE_DEPTH)))
    else $error("Queue count exceeds its depth.");

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("Tag store written and read for the same request.");

  a_selected_legal: assert property (@(posedge clk) disable iff (!rst_n)
    selected_r <= DIR_EAST)
    else $error("Current selection holds an unknown direction code.");

endmodule

// File: hw/rtl/four_queue_round_robin_merge_top.sv
// ----------------------------------------------------------------------------
// four_queue_round_robin_merge_top
// Four tag queues fed by select and push requests and drained round-robin
// by pop requests, one result beat per request.
//
//   Channel  Dir  Signals                                  Beat
//   in_ch    in   req_type, direction, plane_tag           one request
//   out_ch   out  status, out_tag, source_queue            one result
//
// One request per cycle is sustained while results are taken; a request
// beat is first taken by the request register, and a later step then loads
// the result register and reads the popped tag from the tag store, after
// which the result is offered.
// Reset clears the queue pointers, the selection and the service pointer;
// the tag store is not cleared and is only read where it was written.
// A stalled result holds the pipeline; one request beat can still be taken.
// ----------------------------------------------------------------------------
module four_queue_round_robin_merge_top import fqrr_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  fqrr_in_if.sink    in_ch,
  fqrr_out_if.source out_ch
);

  logic                s1_valid_r;
  logic [1:0]          s1_req_r;
  logic [2:0]          s1_dir_r;
  logic [TAG_BITS-1:0] s1_tag_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [QIDX_W-1:0]   out_src_r;
  logic                out_pop_r;

  logic                advance;
  logic                step_en;
  fqrr_res_t           res;
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [TAG_BITS-1:0] mem_wr_data;
  logic                mem_rd_en;
  logic [ADDR_W-1:0]   mem_rd_addr;
  logic [TAG_BITS-1:0] mem_rd_data;

  assign advance     = !out_valid_r || out_ch.ready;
  assign step_en     = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  fqrr_queue_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (step_en),
    .req_type    (s1_req_r),
    .direction   (s1_dir_r),
    .plane_tag   (s1_tag_r),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr)
  );

  fqrr_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_req_r <= in_ch.req_type;
      s1_dir_r <= in_ch.direction;
      s1_tag_r <= TAG_BITS'(in_ch.plane_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_status_r <= res.status;
      out_src_r    <= res.source_queue;
      out_pop_r    <= res.pop_done;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.source_queue = out_src_r;
  assign out_ch.out_tag      = out_pop_r ? 32'(mem_rd_data) : '0;

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_req_r) && $stable(s1_tag_r))
    else $error("Request register changed while the result was stalled.");

  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r)
    else $error("Request side stalled with room in the pipeline.");

  a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |=> out_valid_r && out_pop_r && (out_status_r == ST_DONE))
    else $error("Tag store read without a matching pop result.");

endmodule
